@@ design/mlp_pkg.sv @@
// package for the mlp backprop trainer: sizes, kinds, fixed-point helpers
// no dependencies
`timescale 1ns / 1ps
package mlp_pkg;
    localparam int N_INPUTS  = 4;
    localparam int N_HIDDEN  = 4;
    localparam int FRAC_BITS = 12;
    localparam int N_HW = (N_INPUTS + 1) * N_HIDDEN;
    localparam int N_OW = N_HIDDEN + 1;
    localparam int N_W  = N_HW + N_OW;
    localparam int HID_W = $clog2(N_HIDDEN + 1);
    localparam int ROW_W = $clog2(N_INPUTS + 1);
    localparam int HIDX_W = (N_HIDDEN > 1) ? $clog2(N_HIDDEN) : 1;
    localparam int FIDX_W = (N_INPUTS > 1) ? $clog2(N_INPUTS) : 1;
    localparam logic signed [17:0] ONE = 18'sd1 << FRAC_BITS;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_TRAIN = 2'd1;
    localparam logic [1:0] KIND_INFER = 2'd2;
    localparam logic [1:0] KIND_NOP   = 2'd3;

    // saturate a wide value to 16 bits signed
    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767) return 16'sd32767;
        else if (v < -48'sd32768) return -16'sd32768;
        else return v[15:0];
    endfunction

    // piecewise-linear sigmoid, result 0..ONE
    function automatic logic [12:0] sigm(input logic signed [15:0] z);
        logic [16:0] x;
        logic [16:0] y;
        x = z[15] ? 17'(-$signed({z[15], z})) : {1'b0, z};
        if (x >= 17'(5 << FRAC_BITS))
            y = 17'(1 << FRAC_BITS);
        else if (x >= 17'((19 << FRAC_BITS) / 8))
            y = (x >> 5) + 17'((27 << FRAC_BITS) / 32);
        else if (x >= 17'(1 << FRAC_BITS))
            y = (x >> 3) + 17'((5 << FRAC_BITS) / 8);
        else
            y = (x >> 2) + 17'((1 << FRAC_BITS) / 2);
        if (z[15]) y = 17'(1 << FRAC_BITS) - y;
        return y[12:0];
    endfunction
endpackage

@@ design/mlp_if.sv @@
// valid/ready channel interfaces for input beats, result beats and config writes
// depends on nothing
`timescale 1ns / 1ps
interface mlp_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [4:0]        weight_index;
    logic signed [15:0] weight_value;
    logic signed [15:0] feature_0;
    logic signed [15:0] feature_1;
    logic signed [15:0] feature_2;
    logic signed [15:0] feature_3;
    logic              target;
    modport source (output valid, kind, weight_index, weight_value, feature_0, feature_1,
                    feature_2, feature_3, target, input ready);
    modport sink (input valid, kind, weight_index, weight_value, feature_0, feature_1,
                  feature_2, feature_3, target, output ready);
endinterface

interface mlp_out_if;
    logic              valid;
    logic              ready;
    logic [12:0]       activation;
    logic              prediction;
    logic signed [13:0] output_error;
    modport source (output valid, activation, prediction, output_error, input ready);
    modport sink (input valid, activation, prediction, output_error, output ready);
endinterface

interface mlp_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

@@ design/mlp_backprop_trainer_top.sv @@
// top level of the mlp backprop trainer: sequencer, weight store, result register
// depends on mlp_pkg, mlp_if, mlp_mac
`timescale 1ns / 1ps
// A 4-4-1 sigmoid perceptron with Q4.12 weights, trained online. Every beat is worked on
// alone; ready is low while one runs and while its result waits. A weight write or a no-op
// goes from accept straight to S_DONE, which raises the result valid. An inference and a
// training beat run longer: every product of the forward pass, the deltas and the
// weight updates (two products per weight) goes through one shared 18x18 multiplier
// with a registered product (issue then collect), and both pass the five sigmoid steps.
// Every beat ends with the result load. The result is held in an output register
// until taken. Weights have no reset and must be loaded first.
module mlp_backprop_trainer_top
    import mlp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    mlp_in_if.sink    i_in,
    mlp_out_if.source o_out,
    mlp_cfg_if.sink   i_cfg
);
    typedef enum logic [3:0] {
        S_IDLE, S_HMUL, S_HACC, S_HACT, S_OMUL, S_OACC, S_OACT,
        S_DMUL, S_DACC, S_UMUL, S_UACC, S_UMUL2, S_UACC2, S_DONE
    } t_state;

    t_state r_state;
    logic [12:0] r_lr;
    logic signed [15:0] r_w [N_W];
    logic signed [15:0] r_feat [N_INPUTS];
    logic [1:0]  r_kind;
    logic        r_tgt;
    logic [12:0] r_hs [N_HIDDEN];
    logic signed [15:0] r_hd [N_HIDDEN];
    logic signed [15:0] r_p;
    logic signed [47:0] r_acc;
    logic [ROW_W-1:0] r_row;
    logic [HID_W-1:0] r_col;
    logic [1:0]  r_dstep;
    logic [4:0]  r_widx;
    logic [12:0] r_act;
    logic signed [13:0] r_err;
    logic        r_ovalid;
    logic signed [17:0] s_a, s_b, s_aact, s_dlt;
    logic signed [35:0] s_prod;
    logic [12:0] s_hsv;

    mlp_mac u_mac (.i_clk(i_clk), .i_a(s_a), .i_b(s_b), .o_p(s_prod));

    assign i_in.ready  = (r_state == S_IDLE) && !r_ovalid;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ovalid;
    assign o_out.activation = r_act;
    assign o_out.prediction = r_act > 13'(1 << (FRAC_BITS - 1));
    assign o_out.output_error = r_err;

    // activation of hidden-layer row r_row and of output column r_col (0 is the bias)
    always_comb begin
        s_aact = ONE;
        if (r_row != '0) s_aact = 18'(r_feat[FIDX_W'(r_row - ROW_W'(1))]);
        s_hsv = 13'(1 << FRAC_BITS);
        if (r_col != '0) s_hsv = r_hs[HIDX_W'(r_col - HID_W'(1))];
    end

    // operand select for the shared multiplier
    always_comb begin
        s_a = '0;
        s_b = '0;
        s_dlt = 18'(r_err);
        unique case (r_state)
            S_HMUL: begin
                s_a = 18'(r_w[5'(r_row) * 5'(N_HIDDEN) + 5'(r_col)]);
                s_b = s_aact;
            end
            S_OMUL: begin
                s_a = 18'(r_w[5'(N_HW) + 5'(r_col)]);
                s_b = {5'd0, s_hsv};
            end
            S_DMUL: begin
                unique case (r_dstep)
                    2'd0: begin
                        s_a = 18'(r_w[5'(N_HW) + 5'(r_col) + 5'd1]);
                        s_b = s_dlt;
                    end
                    2'd1: begin
                        s_a = {5'd0, r_hs[HIDX_W'(r_col)]};
                        s_b = ONE - {5'd0, r_hs[HIDX_W'(r_col)]};
                    end
                    default: begin
                        s_a = 18'(r_p);
                        s_b = 18'(r_acc);
                    end
                endcase
            end
            S_UMUL: begin
                if (r_widx >= 5'(N_HW)) begin
                    s_a = {5'd0, s_hsv};
                    s_b = s_dlt;
                end else begin
                    s_a = s_aact;
                    s_b = 18'(r_hd[HIDX_W'(r_col)]);
                end
            end
            S_UMUL2: begin
                s_a = {5'd0, r_lr};
                s_b = 18'(r_acc);
            end
            default: ;
        endcase
    end

    // sequencer, weight store and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_lr     <= 13'd2048;
        end else begin
            if (i_cfg.valid && i_cfg.ready) r_lr <= i_cfg.data;
            if (o_out.valid && o_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in.valid && i_in.ready) begin
                    r_kind  <= i_in.kind;
                    r_tgt   <= i_in.target;
                    r_feat[0] <= i_in.feature_0;
                    r_feat[1] <= i_in.feature_1;
                    r_feat[2] <= i_in.feature_2;
                    r_feat[3] <= i_in.feature_3;
                    r_row <= '0;
                    r_col <= '0;
                    r_acc <= '0;
                    r_err <= '0;
                    if (i_in.kind == KIND_WRITE) begin
                        if (i_in.weight_index < 5'(N_W))
                            r_w[i_in.weight_index] <= i_in.weight_value;
                        r_act <= '0;
                        r_state <= S_DONE;
                    end else if (i_in.kind == KIND_NOP) begin
                        r_act <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_HMUL;
                    end
                end
                S_HMUL: r_state <= S_HACC;
                S_HACC: begin
                    r_acc <= r_acc + 48'(s_prod);
                    if (r_row == ROW_W'(N_INPUTS)) begin
                        r_state <= S_HACT;
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                        r_state <= S_HMUL;
                    end
                end
                S_HACT: begin
                    r_hs[HIDX_W'(r_col)] <= sigm(sat16(r_acc >>> FRAC_BITS));
                    r_acc <= '0;
                    r_row <= '0;
                    if (r_col == HID_W'(N_HIDDEN - 1)) begin
                        r_col <= '0;
                        r_state <= S_OMUL;
                    end else begin
                        r_col <= r_col + HID_W'(1);
                        r_state <= S_HMUL;
                    end
                end
                S_OMUL: r_state <= S_OACC;
                S_OACC: begin
                    r_acc <= r_acc + 48'(s_prod);
                    if (r_col == HID_W'(N_HIDDEN)) begin
                        r_state <= S_OACT;
                    end else begin
                        r_col <= r_col + HID_W'(1);
                        r_state <= S_OMUL;
                    end
                end
                S_OACT: begin
                    logic [12:0] v_act;
                    v_act = sigm(sat16(r_acc >>> FRAC_BITS));
                    r_act <= v_act;
                    r_col <= '0;
                    r_dstep <= '0;
                    if (r_kind == KIND_TRAIN) begin
                        r_err <= 14'(v_act) - (r_tgt ? 14'(1 << FRAC_BITS) : 14'd0);
                        r_state <= S_DMUL;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DMUL: r_state <= S_DACC;
                // delta: p = sat(wo*err), der = s(1-s), hd = p*der
                S_DACC: begin
                    unique case (r_dstep)
                        2'd0: begin
                            r_p <= sat16(48'(s_prod) >>> FRAC_BITS);
                            r_dstep <= 2'd1;
                            r_state <= S_DMUL;
                        end
                        2'd1: begin
                            r_acc <= 48'(s_prod) >>> FRAC_BITS;
                            r_dstep <= 2'd2;
                            r_state <= S_DMUL;
                        end
                        default: begin
                            r_hd[HIDX_W'(r_col)] <= 16'(s_prod >>> FRAC_BITS);
                            r_dstep <= '0;
                            if (r_col == HID_W'(N_HIDDEN - 1)) begin
                                r_col <= '0;
                                r_widx <= 5'(N_HW);
                                r_state <= S_UMUL;
                            end else begin
                                r_col <= r_col + HID_W'(1);
                                r_state <= S_DMUL;
                            end
                        end
                    endcase
                end
                S_UMUL: r_state <= S_UACC;
                S_UACC: begin
                    r_acc <= 48'(s_prod) >>> FRAC_BITS;
                    r_state <= S_UMUL2;
                end
                S_UMUL2: r_state <= S_UACC2;
                // weight update, output weights first then hidden row by row
                S_UACC2: begin
                    r_w[r_widx] <= sat16(48'(r_w[r_widx]) - (48'(s_prod) >>> FRAC_BITS));
                    r_state <= S_UMUL;
                    if (r_widx == 5'(N_W - 1)) begin
                        r_widx <= '0;
                        r_row <= '0;
                        r_col <= '0;
                    end else if (r_widx >= 5'(N_HW)) begin
                        r_widx <= r_widx + 5'd1;
                        r_col <= r_col + HID_W'(1);
                    end else begin
                        r_widx <= r_widx + 5'd1;
                        if (r_col == HID_W'(N_HIDDEN - 1)) begin
                            r_col <= '0;
                            r_row <= r_row + ROW_W'(1);
                        end else begin
                            r_col <= r_col + HID_W'(1);
                        end
                        if (r_widx == 5'(N_HW - 1)) r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ design/mlp_mac.sv @@
// shared multiply unit: registered signed 18x18 product
// depends on mlp_pkg
`timescale 1ns / 1ps
module mlp_mac
    import mlp_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [17:0] i_a,
    input  logic signed [17:0] i_b,
    output logic signed [35:0] o_p
);
    logic signed [35:0] r_p;
    // one multiply per cycle, product registered
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end
    assign o_p = r_p;
endmodule

@@ design/mlp_checker.sv @@
// port-level checker for the mlp backprop trainer, bound to the top level
// depends on mlp_pkg and the top level ports
`timescale 1ns / 1ps
module mlp_checker
    import mlp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [12:0] act,
    input logic        pred,
    input logic signed [13:0] err
);
    // no new beat while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input ready with result pending");
    // an accepted beat keeps the block busy on the next cycle
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready) else $error("input ready right after accept");
    // activation stays in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> act <= 13'(1 << FRAC_BITS)) else $error("activation out of range");
    // prediction follows activation
    a_pred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> pred == (act > 13'(1 << (FRAC_BITS - 1))))
        else $error("prediction mismatch");
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(act) && $stable(err))
        else $error("result changed under stall");
endmodule

bind mlp_backprop_trainer_top mlp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_in.valid), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready),
    .act(o_out.activation), .pred(o_out.prediction), .err(o_out.output_error)
);

@@ tb/mlp_trainer_checker.sv @@
// checker for the mlp backprop trainer: watches input, config and result channels,
// predicts every result with its own copy of weights and learn rate, compares field by field
// depends on mlp_pkg, mlp_if
`timescale 1ns / 1ps
module mlp_trainer_checker
    import mlp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mlp_in_if    i_in,
    mlp_out_if   i_out,
    mlp_cfg_if   i_cfg,
    output int   o_errors,
    output int   o_pending
);
    localparam longint UNIT = longint'(1) << FRAC_BITS;

    typedef struct packed {
        logic [12:0]        activation;
        logic               prediction;
        logic signed [13:0] output_error;
    } result_t;

    logic signed [15:0] hid_w [N_HW];
    logic signed [15:0] out_w [N_OW];
    logic [12:0]        rate;
    result_t            result_q [$];
    int                 errors;

    assign o_errors  = errors;
    assign o_pending = result_q.size();

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // piecewise-linear sigmoid on a saturated neuron sum
    function automatic longint squash(longint z);
        longint x;
        longint y;
        x = (z < 0) ? -z : z;
        if (x >= 5 * UNIT) y = UNIT;
        else if (x >= (19 * UNIT) / 8) y = (x >>> 5) + (27 * UNIT) / 32;
        else if (x >= UNIT) y = (x >>> 3) + (5 * UNIT) / 8;
        else y = (x >>> 2) + UNIT / 2;
        return (z < 0) ? UNIT - y : y;
    endfunction

    function automatic logic signed [15:0] stepped(longint w, longint act, longint delta);
        longint g;
        longint s;
        g = (act * delta) >>> FRAC_BITS;
        s = (longint'(rate) * g) >>> FRAC_BITS;
        return 16'(clip16(w - s));
    endfunction

    // weight write, or forward pass with optional gradient step; returns the expected result beat
    function automatic result_t forward_and_learn(logic [1:0] kind, logic [4:0] idx,
                                                  logic signed [15:0] val,
                                                  logic signed [15:0] f0,
                                                  logic signed [15:0] f1,
                                                  logic signed [15:0] f2,
                                                  logic signed [15:0] f3, logic tgt);
        longint  a [N_INPUTS + 1];
        longint  hs [N_HIDDEN + 1];
        longint  hd [N_HIDDEN];
        longint  acc;
        longint  act;
        longint  err;
        longint  p;
        longint  der;
        result_t r;
        r = '0;
        err = 0;
        if (kind == KIND_WRITE) begin
            if (idx < N_HW) hid_w[idx] = val;
            else if (idx < N_W) out_w[idx - N_HW] = val;
            return r;
        end
        if (kind == KIND_NOP) return r;
        a[0] = UNIT;
        a[1] = f0;
        a[2] = f1;
        a[3] = f2;
        a[4] = f3;
        hs[0] = UNIT;
        for (int j = 0; j < N_HIDDEN; j++) begin
            acc = 0;
            for (int i = 0; i <= N_INPUTS; i++) acc += longint'(hid_w[i * N_HIDDEN + j]) * a[i];
            hs[j + 1] = squash(clip16(acc >>> FRAC_BITS));
        end
        acc = 0;
        for (int j = 0; j <= N_HIDDEN; j++) acc += longint'(out_w[j]) * hs[j];
        act = squash(clip16(acc >>> FRAC_BITS));
        if (kind == KIND_TRAIN) begin
            err = act - (tgt ? UNIT : 0);
            // hidden deltas from the output weights before the step
            for (int j = 0; j < N_HIDDEN; j++) begin
                p = clip16((longint'(out_w[j + 1]) * err) >>> FRAC_BITS);
                der = (hs[j + 1] * (UNIT - hs[j + 1])) >>> FRAC_BITS;
                hd[j] = (p * der) >>> FRAC_BITS;
            end
            for (int j = 0; j <= N_HIDDEN; j++) out_w[j] = stepped(out_w[j], hs[j], err);
            for (int i = 0; i <= N_INPUTS; i++)
                for (int j = 0; j < N_HIDDEN; j++)
                    hid_w[i * N_HIDDEN + j] = stepped(hid_w[i * N_HIDDEN + j], a[i], hd[j]);
        end
        r.activation   = 13'(act);
        r.prediction   = act > UNIT / 2;
        r.output_error = 14'(err);
        return r;
    endfunction

    // sample every channel on the clock edge
    always @(posedge i_clk) begin
        result_t got;
        result_t want;
        if (!i_rst_n) begin
            rate = 13'd2048;
            result_q.delete();
            errors = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) rate = i_cfg.data;
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.activation, i_out.prediction, i_out.output_error};
                if (result_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    if (got.activation !== want.activation) begin
                        $error("activation expected %0d got %0d", want.activation,
                               got.activation);
                        errors++;
                    end
                    if (got.prediction !== want.prediction) begin
                        $error("prediction expected %0d got %0d", want.prediction,
                               got.prediction);
                        errors++;
                    end
                    if (got.output_error !== want.output_error) begin
                        $error("output_error expected %0d got %0d", want.output_error,
                               got.output_error);
                        errors++;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                result_q.push_back(forward_and_learn(i_in.kind, i_in.weight_index,
                    i_in.weight_value, i_in.feature_0, i_in.feature_1, i_in.feature_2,
                    i_in.feature_3, i_in.target));
        end
    end
endmodule

@@ tb/mlp_backprop_trainer_top_test.sv @@
// testbench top for the mlp backprop trainer: clock, reset, stimulus and verdict;
// results are predicted and compared by mlp_trainer_checker
// depends on mlp_pkg, mlp_if, mlp_trainer_checker, mlp_backprop_trainer_top
`timescale 1ns / 1ps
module mlp_backprop_trainer_top_test;
    import mlp_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;
    bit   quiet = 1'b0;
    bit   hold_go = 1'b0;
    bit   hold_seen = 1'b0;
    int   hold_cnt = 0;
    int   burst = 0;
    int   n_train = 0;
    int   n_infer = 0;
    int   n_write = 0;
    int   n_cfg = 0;

    mlp_in_if  in_ch ();
    mlp_out_if out_ch ();
    mlp_cfg_if cfg_ch ();

    mlp_backprop_trainer_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    mlp_trainer_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #10 i_clk = ~i_clk;

    // result side: random stall bursts plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_go && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_cnt  <= 400;
            out_ch.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            out_ch.ready <= 1'b0;
        end else if (burst > 0) begin
            burst <= burst - 1;
            out_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            burst <= $urandom_range(0, 15);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    initial begin
        out_ch.ready = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_NOP;
        in_ch.weight_index = '0;
        in_ch.weight_value = '0;
        in_ch.feature_0 = '0;
        in_ch.feature_1 = '0;
        in_ch.feature_2 = '0;
        in_ch.feature_3 = '0;
        in_ch.target = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
    end

    // one input beat, with an optional random gap before it
    task automatic send_beat(logic [1:0] kind, logic [4:0] idx, logic signed [15:0] val,
                             logic signed [15:0] f0, logic signed [15:0] f1,
                             logic signed [15:0] f2, logic signed [15:0] f3, logic tgt);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind;
        in_ch.weight_index <= idx;
        in_ch.weight_value <= val;
        in_ch.feature_0 <= f0;
        in_ch.feature_1 <= f1;
        in_ch.feature_2 <= f2;
        in_ch.feature_3 <= f3;
        in_ch.target <= tgt;
        do @(posedge i_clk); while (!in_ch.ready);
        case (kind)
            KIND_TRAIN: n_train++;
            KIND_INFER: n_infer++;
            KIND_WRITE: n_write++;
            default: ;
        endcase
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // learn rate write, only with the block idle
    task automatic set_rate(logic [12:0] r);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= r;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        n_cfg++;
    endtask

    function automatic logic signed [15:0] feat();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 16384)) - 8192);
            default: return 16'($signed($urandom_range(0, 4096)) - 2048);
        endcase
    endfunction

    function automatic logic signed [15:0] wgt();
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 8192)) - 4096);
    endfunction

    task automatic load_all();
        for (int k = 0; k < N_W; k++) send_beat(KIND_WRITE, 5'(k), wgt(), 0, 0, 0, 0, 0);
    endtask

    task automatic random_beat();
        int          sel;
        logic [1:0]  k;
        sel = $urandom_range(0, 99);
        k = (sel < 15) ? KIND_WRITE : (sel < 57) ? KIND_TRAIN : (sel < 95) ? KIND_INFER
                                                                          : KIND_NOP;
        send_beat(k, 5'($urandom), (k == KIND_WRITE) ? wgt() : 16'($urandom),
                  feat(), feat(), feat(), feat(), 1'($urandom));
    endtask

    logic [12:0] rates [6] = '{13'd4096, 13'd1, 13'd8191, 13'd300, 13'd0, 13'd2048};

    // stimulus
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: ignored writes, nop, extreme weights, all weights, extreme features
        send_beat(KIND_WRITE, 5'd25, 16'sh7fff, 0, 0, 0, 0, 0);
        send_beat(KIND_WRITE, 5'd31, -16'sd32768, 0, 0, 0, 0, 0);
        send_beat(KIND_NOP, 5'd31, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1);
        load_all();
        send_beat(KIND_WRITE, 5'd0, 16'sh7fff, 0, 0, 0, 0, 0);
        send_beat(KIND_WRITE, 5'd24, -16'sd32768, 0, 0, 0, 0, 0);
        send_beat(KIND_INFER, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
        send_beat(KIND_INFER, 0, 0, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1);
        send_beat(KIND_TRAIN, 0, 0, 16'sh7fff, -16'sd32768, 0, 16'sd4096, 0);
        send_beat(KIND_TRAIN, 0, 0, 0, 0, 0, 0, 1);
        send_beat(KIND_TRAIN, 0, 0, -16'sd32768, 16'sh7fff, 16'sd100, -16'sd4096, 1);
        send_beat(KIND_NOP, 0, 0, 0, 0, 0, 0, 0);
        load_all();

        // random phases, one learn rate each
        for (int ph = 0; ph < 6; ph++) begin
            set_rate(rates[ph]);
            if (ph == 5) quiet = 1'b1;
            for (int n = 0; n < 200; n++) begin
                if (ph == 1 && n == 20) hold_go = 1'b1;
                if (ph == 2 && n == 100) drain();
                random_beat();
            end
            if (ph == 3) load_all();
        end

        drain();
        repeat (200) @(posedge i_clk);
        $display("covered %0d training, %0d inference, %0d weight beats", n_train, n_infer,
                 n_write);
        $display("across %0d learn rate settings with stalls on both sides", n_cfg);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    // hard limit on run length
    initial begin
        #40ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

@@ filelist.f @@
design/mlp_pkg.sv
design/mlp_if.sv
design/mlp_mac.sv
design/mlp_backprop_trainer_top.sv
design/mlp_checker.sv
tb/mlp_trainer_checker.sv
tb/mlp_backprop_trainer_top_test.sv
